// File: rtl/ffba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, command codes and control structs of the first-fit
// bitmap allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    // Bitmap geometry
    localparam int BITMAP_BYTES = 1024;
    localparam int BYTE_W       = 8;
    localparam int WORD_BYTES   = 8;
    localparam int WORD_BITS    = WORD_BYTES * BYTE_W;
    localparam int WORDS        = (BITMAP_BYTES + WORD_BYTES - 1) / WORD_BYTES;
    localparam int WORD_AW      = $clog2(WORDS);
    localparam int BIT_AW       = $clog2(WORD_BITS);
    localparam int BYTE_SEL_W   = $clog2(WORD_BYTES);

    // Item field widths
    localparam int CMD_W      = 2;
    localparam int UNIT_W     = 13;
    localparam int BYTE_IDX_W = 10;
    localparam int COUNT_W    = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Width used for byte-position range checks
    localparam int IDX_CMP_W = 14;

    // Input tdata layout, lowest field first
    localparam int IN_UNIT_LSB  = 0;
    localparam int IN_BIDX_LSB  = IN_UNIT_LSB + UNIT_W;
    localparam int IN_BVAL_LSB  = IN_BIDX_LSB + BYTE_IDX_W;
    localparam int IN_CVAL_LSB  = IN_BVAL_LSB + BYTE_W;
    localparam int S_TDATA_W    = ((IN_CVAL_LSB + COUNT_W + 7) / 8) * 8;

    // Output tdata layout, lowest field first
    localparam int OUT_UNIT_LSB = 0;
    localparam int OUT_CNT_LSB  = OUT_UNIT_LSB + UNIT_W;
    localparam int M_TDATA_W    = ((OUT_CNT_LSB + COUNT_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC     = 2'd0,
        CMD_FREE      = 2'd1,
        CMD_LOAD_BYTE = 2'd2,
        CMD_SET_COUNT = 2'd3
    } cmd_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // item taken, issue bitmap read
        logic exec;     // modify, write back and post result
    } ffba_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free; // result register can take a new item
    } ffba_sts_t;

endpackage

// File: rtl/ffba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_ctrl
// Two-state sequencer: take an item and read its bitmap word, then
// modify and write back once the result register is free.
// ----------------------------------------------------------------------------
module ffba_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ffba_pkg::ffba_sts_t sts,
    output ffba_pkg::ffba_ctl_t ctl
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    // Commands to the datapath
    always_comb
    begin
        ctl.accept = ready_reg && s_tvalid;
        ctl.exec   = (state_reg == S_EXEC) && sts.out_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (ctl.accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (ctl.exec)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        ready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

endmodule

// File: rtl/ffba_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffba_dp
// Bitmap memory of 64-bit words with per-word valid and full flags,
// free-unit counter, first-fit search and the result register.
// ----------------------------------------------------------------------------
module ffba_dp
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  ffba_pkg::ffba_ctl_t              ctl,
    output ffba_pkg::ffba_sts_t              sts,
    input  logic [ffba_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [ffba_pkg::CMD_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ffba_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tuser
);

    // Bitmap store: entries not yet written read as zero
    logic [ffba_pkg::WORD_BITS-1:0] mem [ffba_pkg::WORDS];
    logic [ffba_pkg::WORDS-1:0]     valid_reg;
    logic [ffba_pkg::WORDS-1:0]     full_reg;
    logic [ffba_pkg::WORD_BITS-1:0] rd_reg;
    logic                           rdv_reg;

    // Item held during execution
    ffba_pkg::cmd_t                  cmd_reg;
    logic [ffba_pkg::UNIT_W-1:0]     unit_reg;
    logic [ffba_pkg::BYTE_IDX_W-1:0] bidx_reg;
    logic [ffba_pkg::BYTE_W-1:0]     bval_reg;
    logic [ffba_pkg::COUNT_W-1:0]    cval_reg;
    logic [ffba_pkg::WORD_AW-1:0]    waddr_reg;
    logic                            hit_reg;

    logic [ffba_pkg::COUNT_W-1:0]    count_reg;
    logic [ffba_pkg::COUNT_W-1:0]    count_next;

    logic                            out_valid_reg;
    logic [ffba_pkg::UNIT_W-1:0]     out_unit_reg;
    logic [ffba_pkg::COUNT_W-1:0]    out_count_reg;
    logic                            out_found_reg;

    // Incoming fields
    ffba_pkg::cmd_t                  in_cmd;
    logic [ffba_pkg::UNIT_W-1:0]     in_unit;
    logic [ffba_pkg::BYTE_IDX_W-1:0] in_bidx;
    logic [ffba_pkg::BYTE_W-1:0]     in_bval;
    logic [ffba_pkg::COUNT_W-1:0]    in_cval;

    logic [ffba_pkg::WORD_AW-1:0]    pick_word;
    logic                            pick_any;
    logic [ffba_pkg::WORD_AW-1:0]    raddr;

    logic [ffba_pkg::WORD_BITS-1:0]  word_q;
    logic [ffba_pkg::WORD_BITS-1:0]  wdata;
    logic [ffba_pkg::BIT_AW-1:0]     bit_sel;
    logic                            free_ok;
    logic                            load_ok;
    logic                            alloc_hit;
    logic                            wr_en;

    assign in_cmd  = ffba_pkg::cmd_t'(s_tuser);
    assign in_unit = s_tdata[ffba_pkg::IN_UNIT_LSB +: ffba_pkg::UNIT_W];
    assign in_bidx = s_tdata[ffba_pkg::IN_BIDX_LSB +: ffba_pkg::BYTE_IDX_W];
    assign in_bval = s_tdata[ffba_pkg::IN_BVAL_LSB +: ffba_pkg::BYTE_W];
    assign in_cval = s_tdata[ffba_pkg::IN_CVAL_LSB +: ffba_pkg::COUNT_W];

    // Lowest word that still has a clear bit
    always_comb
    begin
        pick_word = '0;
        pick_any  = 1'b0;
        for (int i = ffba_pkg::WORDS - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                pick_word = ffba_pkg::WORD_AW'(i);
                pick_any  = 1'b1;
            end
        end
    end

    // Word address of the incoming item
    always_comb
    begin
        case (in_cmd)
            ffba_pkg::CMD_ALLOC:
                raddr = pick_word;
            ffba_pkg::CMD_FREE:
                raddr = in_unit[ffba_pkg::BIT_AW +: ffba_pkg::WORD_AW];
            ffba_pkg::CMD_LOAD_BYTE:
                raddr = in_bidx[ffba_pkg::BYTE_SEL_W +: ffba_pkg::WORD_AW];
            default:
                raddr = '0;
        endcase
    end

    // Latch the item on accept
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg   <= in_cmd;
            unit_reg  <= in_unit;
            bidx_reg  <= in_bidx;
            bval_reg  <= in_bval;
            cval_reg  <= in_cval;
            waddr_reg <= raddr;
            hit_reg   <= pick_any;
        end
    end

    // Memory: registered read on accept, write back on execute
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            rd_reg <= mem[raddr];
        end
        if (wr_en)
        begin
            mem[waddr_reg] <= wdata;
        end
    end

    assign word_q = rdv_reg ? rd_reg : '0;

    // Lowest clear bit of the chosen word
    always_comb
    begin
        bit_sel = '0;
        for (int b = ffba_pkg::WORD_BITS - 1; b >= 0; b--)
        begin
            if (!word_q[b])
            begin
                bit_sel = ffba_pkg::BIT_AW'(b);
            end
        end
    end

    // Range checks on byte positions
    assign free_ok = ffba_pkg::IDX_CMP_W'(unit_reg >> ffba_pkg::BYTE_SEL_W)
                     < ffba_pkg::IDX_CMP_W'(ffba_pkg::BITMAP_BYTES);
    assign load_ok = ffba_pkg::IDX_CMP_W'(bidx_reg)
                     < ffba_pkg::IDX_CMP_W'(ffba_pkg::BITMAP_BYTES);
    assign alloc_hit = (cmd_reg == ffba_pkg::CMD_ALLOC) && hit_reg;

    // Modified word, write enable and counter update
    always_comb
    begin
        wdata      = word_q;
        wr_en      = 1'b0;
        count_next = count_reg;
        case (cmd_reg)
            ffba_pkg::CMD_ALLOC:
            begin
                if (hit_reg)
                begin
                    wdata[bit_sel] = 1'b1;
                    wr_en          = ctl.exec;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            ffba_pkg::CMD_FREE:
            begin
                if (free_ok)
                begin
                    wdata[unit_reg[ffba_pkg::BIT_AW-1:0]] = 1'b0;
                    wr_en = ctl.exec;
                    if (count_reg != ffba_pkg::COUNT_MAX)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ffba_pkg::CMD_LOAD_BYTE:
            begin
                if (load_ok)
                begin
                    wdata[bidx_reg[ffba_pkg::BYTE_SEL_W-1:0] * ffba_pkg::BYTE_W
                          +: ffba_pkg::BYTE_W] = bval_reg;
                    wr_en = ctl.exec;
                end
            end
            ffba_pkg::CMD_SET_COUNT:
            begin
                count_next = cval_reg;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Flags, counter and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            full_reg      <= '0;
            rdv_reg       <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.accept)
            begin
                rdv_reg <= valid_reg[raddr];
            end
            if (wr_en)
            begin
                valid_reg[waddr_reg] <= 1'b1;
                full_reg[waddr_reg]  <= &wdata;
            end
            if (ctl.exec)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            out_unit_reg  <= alloc_hit ? ffba_pkg::UNIT_W'({waddr_reg, bit_sel}) : '0;
            out_found_reg <= alloc_hit;
            out_count_reg <= count_next;
        end
    end

    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tuser      = out_found_reg;

    always_comb
    begin
        m_tdata = '0;
        m_tdata[ffba_pkg::OUT_UNIT_LSB +: ffba_pkg::UNIT_W] = out_unit_reg;
        m_tdata[ffba_pkg::OUT_CNT_LSB +: ffba_pkg::COUNT_W] = out_count_reg;
    end

endmodule

// File: rtl/first_fit_bitmap_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_bitmap_allocator_unit
// First-fit unit allocator over an 8192-unit bitmap with a free counter.
//
// Usage:
//   Input items arrive on s_*: s_tuser carries the command (allocate, free
//   unit, load bitmap byte, set free count), s_tdata the operands. Every item
//   gives exactly one result item on m_*: m_tdata of the result holds the
//   granted unit and the free count, m_tuser the found flag.
//   One item is worked on at a time. In the accept cycle the word to touch
//   is chosen (a priority encoder over the 128 per-word full flags for
//   allocate) and the 64-bit bitmap word is read; in the execute cycle,
//   which waits until the result register is free, the word is modified and
//   written back through the single memory port and the result register is
//   loaded. m_tvalid rises and s_tready returns at the end of that cycle.
//   After reset the bitmap reads as all clear (per-word valid flags, no
//   clearing sweep) and the counter is zero; the block takes items at once.
//   When the receiver stalls, the result waits in its register; the next
//   item is still accepted and its read performed, and it then holds in its
//   execute cycle until the result register is taken.
// ----------------------------------------------------------------------------
module first_fit_bitmap_allocator_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [12:0] unit_number, [22:13] byte_index, [30:23] byte_value,
    // [46:31] count_value, [47] zero
    input  logic [ffba_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] cmd
    input  logic [ffba_pkg::CMD_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [12:0] allocated_unit, [28:13] free_count, [31:29] zero
    output logic [ffba_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] found
    output logic                           m_tuser
);

    ffba_pkg::ffba_ctl_t ctl;
    ffba_pkg::ffba_sts_t sts;

    ffba_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    ffba_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // One item in flight: no second accept straight after an accept
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while previous one still executing");

    // Execution never overlaps an accept
    a_exec_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |-> !ctl.accept)
        else $error("execute and accept in the same cycle");

    // A result without a grant carries unit zero
    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[ffba_pkg::UNIT_W-1:0] == '0))
        else $error("non-zero unit reported without a grant");

    // Each execute loads a result that is then shown
    a_exec_posts: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.exec |=> m_tvalid)
        else $error("executed item produced no result");

endmodule
